@@ src/sconv_pkg.sv @@
// Shared constants and types for the strided int8 1-D convolution block.
`default_nettype none
package sconv_pkg;

    localparam int SAMPLE_W     = 8;
    localparam int PROD_W       = 16;
    localparam int RESULT_W     = 19;
    localparam int CNT_W        = 16;
    localparam int TAPS_IN_REG  = 8;
    localparam int TAPS_W       = 64;
    localparam int TAP_COUNT_W  = 4;
    localparam int STRIDE_W     = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;

    localparam int DEF_MAX_TAPS   = 8;
    localparam int DEF_MAX_STRIDE = 8;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 4'd8;
    localparam logic [STRIDE_W-1:0]    STRIDE_RST    = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAPS         = 2'd0,
        CFG_TAP_COUNT    = 2'd1,
        CFG_STRIDE       = 2'd2,
        CFG_OUTPUT_COUNT = 2'd3
    } cfg_idx_t;

    // per-item decision from the sequence counters
    typedef struct packed {
        logic             emit;
        logic [CNT_W-1:0] index;
        logic             last;
    } emit_t;

endpackage
`default_nettype wire

@@ src/sconv_cell.sv @@
// One delay-line cell: holds a window sample and its registered tap product.
`default_nettype none
module sconv_cell #(
    parameter int MAX_TAPS = sconv_pkg::DEF_MAX_TAPS,
    parameter int IDX      = 0,
    localparam int NT_W    = $clog2(MAX_TAPS + 1)
) (
    input  wire                                        clk,
    input  wire                                        shift_en,
    input  wire logic signed [sconv_pkg::SAMPLE_W-1:0] din,
    output logic signed [sconv_pkg::SAMPLE_W-1:0]      dout,
    input  wire logic [sconv_pkg::TAPS_W-1:0]          taps_packed,
    input  wire logic [NT_W-1:0]                       nt,
    output logic signed [sconv_pkg::PROD_W-1:0]        prod
);

    logic signed [sconv_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [sconv_pkg::PROD_W-1:0]   prod_reg;
    logic signed [sconv_pkg::SAMPLE_W-1:0] coef;
    logic [NT_W-1:0]                       tap_idx;

    // this cell holds the sample that meets tap (nt-1-IDX)
    always_comb
    begin
        tap_idx = nt - NT_W'(IDX + 1);
        coef    = '0;
        if (int'(nt) > IDX)
        begin
            for (int j = 0; j < sconv_pkg::TAPS_IN_REG; j++)
            begin
                if (int'(tap_idx) == j)
                    coef = taps_packed[j*sconv_pkg::SAMPLE_W +: sconv_pkg::SAMPLE_W];
            end
        end
    end

    // cells past the tap count give a hard zero, whatever sample they hold
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            sample_reg <= din;
            if (int'(nt) > IDX)
                prod_reg <= din * coef;
            else
                prod_reg <= '0;
        end
    end

    assign dout = sample_reg;
    assign prod = prod_reg;

endmodule
`default_nettype wire

@@ src/sconv_ctrl.sv @@
// Sequence counters: fill count, stride phase and output count.
`default_nettype none
module sconv_ctrl #(
    parameter int MAX_TAPS   = sconv_pkg::DEF_MAX_TAPS,
    parameter int MAX_STRIDE = sconv_pkg::DEF_MAX_STRIDE,
    localparam int NT_W      = $clog2(MAX_TAPS + 1),
    localparam int ST_W      = $clog2(MAX_STRIDE + 1)
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   accept,
    input  wire                                   start_req,
    input  wire logic [NT_W-1:0]                  nt,
    input  wire logic [ST_W-1:0]                  st,
    input  wire logic [sconv_pkg::CNT_W-1:0]      output_count,
    output sconv_pkg::emit_t                      info
);

    logic [NT_W-1:0]             seen_reg, seen_next;
    logic [ST_W-1:0]             phase_reg, phase_next;
    logic [sconv_pkg::CNT_W-1:0] done_reg, done_next;

    logic [NT_W-1:0]             seen_base;
    logic [ST_W-1:0]             phase_base, ph;
    logic [ST_W:0]               ph_inc;
    logic [sconv_pkg::CNT_W-1:0] done_base;

    always_comb
    begin
        seen_base  = start_req ? '0 : seen_reg;
        phase_base = start_req ? '0 : phase_reg;
        done_base  = start_req ? '0 : done_reg;

        // fill count only needs to reach the largest tap count
        seen_next = (int'(seen_base) < MAX_TAPS) ? seen_base + NT_W'(1) : seen_base;

        ph         = (phase_base >= st) ? '0 : phase_base;
        ph_inc     = {1'b0, ph} + (ST_W+1)'(1);
        phase_next = phase_base;
        info.emit  = 1'b0;
        if (seen_next >= nt)
        begin
            info.emit  = (ph == '0) && (done_base < output_count);
            phase_next = (ph_inc >= {1'b0, st}) ? '0 : ph_inc[ST_W-1:0];
        end

        info.index = done_base;
        info.last  = ({1'b0, done_base} + 17'd1) == {1'b0, output_count};
        done_next  = info.emit ? done_base + sconv_pkg::CNT_W'(1) : done_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            phase_reg <= '0;
            done_reg  <= '0;
        end
        else if (accept)
        begin
            seen_reg  <= seen_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

endmodule
`default_nettype wire

@@ src/strided_int8_conv1d.sv @@
// Path: a result passes the cell product registers, then the adder-tree output register, before it leaves.
// Throughput: one sample per cycle; the cell row, the product registers and the
// adder-tree output register each move one item per cycle, stalls back up per stage.
// Reset (rst_n, async): counters and valids clear, registers take their reset values;
// the delay line is not cleared, it is only read once refilled.
`default_nettype none
module strided_int8_conv1d #(
    parameter int MAX_TAPS   = sconv_pkg::DEF_MAX_TAPS,
    parameter int MAX_STRIDE = sconv_pkg::DEF_MAX_STRIDE
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire                                        cfg_write_en,
    input  wire logic [sconv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [sconv_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                        in_valid,
    output logic                                       in_stall,
    input  wire logic signed [sconv_pkg::SAMPLE_W-1:0] sample,
    input  wire                                        start_req,
    output logic                                       out_valid,
    input  wire                                        out_stall,
    output logic signed [sconv_pkg::RESULT_W-1:0]      result,
    output logic [sconv_pkg::CNT_W-1:0]                result_index,
    output logic                                       last_result
);

    localparam int NT_W   = $clog2(MAX_TAPS + 1);
    localparam int ST_W   = $clog2(MAX_STRIDE + 1);
    localparam int EXT_W  = sconv_pkg::RESULT_W - sconv_pkg::PROD_W;

    logic [sconv_pkg::TAPS_W-1:0]      taps_packed_reg;
    logic [sconv_pkg::TAP_COUNT_W-1:0] tap_count_reg;
    logic [sconv_pkg::STRIDE_W-1:0]    stride_reg;
    logic [sconv_pkg::CNT_W-1:0]       output_count_reg;

    logic [NT_W-1:0] nt;
    logic [ST_W-1:0] st;

    logic                                  accept, s1_move, s2_move;
    sconv_pkg::emit_t                      info;
    logic                                  s1_valid_reg;
    logic [sconv_pkg::CNT_W-1:0]           s1_index_reg;
    logic                                  s1_last_reg;
    logic                                  out_valid_reg;
    logic signed [sconv_pkg::RESULT_W-1:0] result_reg, result_next;
    logic [sconv_pkg::CNT_W-1:0]           index_reg;
    logic                                  last_reg;

    logic signed [sconv_pkg::SAMPLE_W-1:0] chain [MAX_TAPS+1];
    logic signed [sconv_pkg::PROD_W-1:0]   prod  [MAX_TAPS];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_packed_reg  <= '0;
            tap_count_reg    <= sconv_pkg::TAP_COUNT_RST;
            stride_reg       <= sconv_pkg::STRIDE_RST;
            output_count_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (sconv_pkg::cfg_idx_t'(cfg_index))
                sconv_pkg::CFG_TAPS:
                    taps_packed_reg <= cfg_data;
                sconv_pkg::CFG_TAP_COUNT:
                    tap_count_reg <= cfg_data[sconv_pkg::TAP_COUNT_W-1:0];
                sconv_pkg::CFG_STRIDE:
                    stride_reg <= cfg_data[sconv_pkg::STRIDE_W-1:0];
                sconv_pkg::CFG_OUTPUT_COUNT:
                    output_count_reg <= cfg_data[sconv_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp tap count and stride into 1..max
    always_comb
    begin
        if (tap_count_reg == '0)
            nt = NT_W'(1);
        else if (int'(tap_count_reg) > MAX_TAPS)
            nt = NT_W'(MAX_TAPS);
        else
            nt = NT_W'(tap_count_reg);

        if (stride_reg == '0)
            st = ST_W'(1);
        else if (int'(stride_reg) > MAX_STRIDE)
            st = ST_W'(MAX_STRIDE);
        else
            st = ST_W'(stride_reg);
    end

    // per-stage flow control
    assign s2_move  = !out_valid_reg || !out_stall;
    assign s1_move  = !s1_valid_reg || s2_move;
    assign in_stall = !s1_move;
    assign accept   = in_valid && s1_move;

    sconv_ctrl #(
        .MAX_TAPS   (MAX_TAPS),
        .MAX_STRIDE (MAX_STRIDE)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .start_req    (start_req),
        .nt           (nt),
        .st           (st),
        .output_count (output_count_reg),
        .info         (info)
    );

    assign chain[0] = sample;

    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        sconv_cell #(
            .MAX_TAPS (MAX_TAPS),
            .IDX      (k)
        ) u_cell (
            .clk         (clk),
            .shift_en    (accept),
            .din         (chain[k]),
            .dout        (chain[k+1]),
            .taps_packed (taps_packed_reg),
            .nt          (nt),
            .prod        (prod[k])
        );
    end

    // adder tree over the cell products; sums wrap at the result width
    always_comb
    begin
        result_next = '0;
        for (int k = 0; k < MAX_TAPS; k++)
            result_next = result_next + {{EXT_W{prod[k][sconv_pkg::PROD_W-1]}}, prod[k]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_move)
                s1_valid_reg <= accept && info.emit;
            if (s2_move)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_index_reg <= info.index;
            s1_last_reg  <= info.last;
        end
        if (s2_move && s1_valid_reg)
        begin
            result_reg <= result_next;
            index_reg  <= s1_index_reg;
            last_reg   <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result       = result_reg;
    assign result_index = index_reg;
    assign last_result  = last_reg;

endmodule
`default_nettype wire
